// ----- rtl/tcd_pkg.sv -----
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared widths, reset values and codes of the tube centerline decimator.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

    // Width of the running point index
    localparam int IDX_W = 16;

    // Stream widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 144;
    localparam int OUT_USER_W = 1;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // Register reset values (0.975 and 0.025 in Q0.16)
    localparam logic [15:0] COS_LIMIT_RST = 16'd63898;
    localparam logic [15:0] RAD_TOL_RST   = 16'd1638;

    // Register indexes (taken from paddr[2])
    localparam logic REG_COS_LIMIT = 1'b0;
    localparam logic REG_RAD_TOL   = 1'b1;

    // Write-back destination of the shared multiplier
    typedef logic [2:0] t_dst;
    localparam t_dst DST_NONE  = 3'd0;
    localparam t_dst DST_CL    = 3'd1;
    localparam t_dst DST_TL    = 3'd2;
    localparam t_dst DST_POS   = 3'd3;
    localparam t_dst DST_NEG   = 3'd4;
    localparam t_dst DST_ACC   = 3'd5;
    localparam t_dst DST_ACCLR = 3'd6;
    localparam t_dst DST_COS2  = 3'd7;

    // One result item
    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        rad;
        logic [IDX_W-1:0]   idx;
        logic               last;
        logic               shrt;
    } t_res;

endpackage

`default_nettype wire

// ----- rtl/tube_centerline_decimator.sv -----
// Sequence: a first, second or untested point goes from accept to decide, then
// to emit when it has results; a tested point first runs 27 multiplier steps.
// A new point is taken only when all results of the last one have entered the
// output register, so a stalled result holds the input. The single shared 33x33
// multiplier builds all squared terms.
// Reset: synchronous, active low; wait for the first point, index and registers at defaults.
// ----------------------------------------------------------------------------
// tube_centerline_decimator
// Reduces a streamed tube centerline to its direction and radius break points.
// ----------------------------------------------------------------------------
`default_nettype none

module tube_centerline_decimator (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input items
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [tcd_pkg::IN_DATA_W-1:0]      i_s_tdata,  // pos_x, pos_y, pos_z, tube_radius
    input  logic                               i_s_tlast,  // final_point
    // result items
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    output logic [tcd_pkg::OUT_DATA_W-1:0]     o_m_tdata,  // kept_x, kept_y, kept_z,
                                                           // kept_radius, kept_index
    output logic                               o_m_tlast,  // line_end
    output logic [tcd_pkg::OUT_USER_W-1:0]     o_m_tuser,  // too_short
    // configuration
    input  logic                               i_psel,
    input  logic                               i_penable,
    input  logic                               i_pwrite,
    input  logic [tcd_pkg::APB_ADDR_W-1:0]     i_paddr,
    input  logic [tcd_pkg::APB_DATA_W-1:0]     i_pwdata,
    output logic [tcd_pkg::APB_DATA_W-1:0]     o_prdata,
    output logic                               o_pready
);
    import tcd_pkg::*;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CALC   = 2'd1;
    localparam logic [1:0] ST_DECIDE = 2'd2;
    localparam logic [1:0] ST_EMIT   = 2'd3;

    localparam logic [1:0] PH_FIRST  = 2'd0;
    localparam logic [1:0] PH_SECOND = 2'd1;
    localparam logic [1:0] PH_TEST   = 2'd2;
    localparam logic [1:0] PH_SKIP   = 2'd3;

    localparam logic [4:0] STEP_DOT  = 5'd10;
    localparam logic [4:0] STEP_LHS  = 5'd16;
    localparam logic [4:0] STEP_PP   = 5'd20;
    localparam logic [4:0] STEP_LAST = 5'd26;

    // control
    logic [1:0]         r_st;
    logic [1:0]         r_phase;
    logic [4:0]         r_step;
    logic               r_kept;
    logic [1:0]         r_nres;
    logic               r_ridx;
    logic               r_ovalid;
    t_dst               r_dst;
    logic [1:0]         r_sh;

    // tube state
    logic signed [31:0] r_anc [3];
    logic [31:0]        r_hold;
    logic signed [32:0] r_t [3];
    logic [31:0]        r_ref;
    logic [IDX_W-1:0]   r_cnt;
    logic [15:0]        r_cos;
    logic [15:0]        r_tol;

    // current item and datapath
    logic signed [31:0] r_p [3];
    logic [31:0]        r_prad;
    logic               r_pfin;
    logic signed [32:0] r_c [3];
    logic [65:0]        r_prod;
    logic [65:0]        r_cl;
    logic [65:0]        r_tl;
    logic [65:0]        r_pos;
    logic [65:0]        r_neg;
    logic [65:0]        r_dot;
    logic [31:0]        r_cos2;
    logic [47:0]        r_rt;
    logic [131:0]       r_lhs;
    logic [131:0]       r_pp;
    logic [163:0]       r_acc;
    t_res               r_res [2];
    t_res               r_out;

    logic               accept;
    logic               cfg_wr;
    logic signed [31:0] in_p [3];
    logic [31:0]        in_rad;

    logic [32:0]        mul_a;
    logic [32:0]        mul_b;
    t_dst               iss_dst;
    logic [1:0]         iss_sh;
    logic [1:0]         iss_i;
    logic [1:0]         iss_k;
    logic [163:0]       acc_add;

    logic               c_zero;
    logic               t_zero;
    logic [31:0]        rad_diff;
    logic               kept;

    t_res               pt;
    t_res               d_r0;
    t_res               d_r1;
    logic [1:0]         d_n;
    logic [1:0]         d_phase;
    logic [IDX_W-1:0]   d_cnt;
    logic [IDX_W-1:0]   cnt1;
    logic               d_anc;
    logic               d_hold;
    logic               d_tan;
    logic               d_ref;

    function automatic logic [32:0] mag33(input logic signed [32:0] v);
        mag33 = v[32] ? 33'(-v) : 33'(v);
    endfunction

    // unpack input fields
    assign in_p[0] = i_s_tdata[31:0];
    assign in_p[1] = i_s_tdata[63:32];
    assign in_p[2] = i_s_tdata[95:64];
    assign in_rad  = i_s_tdata[127:96];

    assign o_s_tready = (r_st == ST_IDLE);
    assign accept     = i_s_tvalid && o_s_tready;

    // configuration port
    assign o_pready = 1'b1;
    assign cfg_wr   = i_psel && i_penable && i_pwrite;
    assign o_prdata = {16'b0, (i_paddr[2] == REG_RAD_TOL) ? r_tol : r_cos};

    // issue at most one multiplication per step
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        iss_dst = DST_NONE;
        iss_sh  = 2'd0;
        iss_i   = 2'(r_step);
        iss_k   = 2'(r_step[1:0] - 2'd3);
        if (r_st == ST_CALC) begin
            case (r_step)
                5'd0, 5'd1, 5'd2: begin
                    iss_i   = 2'(r_step);
                    mul_a   = mag33(r_c[iss_i]);
                    mul_b   = mag33(r_c[iss_i]);
                    iss_dst = DST_CL;
                end
                5'd3, 5'd4, 5'd5: begin
                    iss_i   = 2'(r_step - 5'd3);
                    mul_a   = mag33(r_t[iss_i]);
                    mul_b   = mag33(r_t[iss_i]);
                    iss_dst = DST_TL;
                end
                5'd6, 5'd7, 5'd8: begin
                    iss_i   = 2'(r_step - 5'd6);
                    mul_a   = mag33(r_c[iss_i]);
                    mul_b   = mag33(r_t[iss_i]);
                    iss_dst = (r_c[iss_i][32] != r_t[iss_i][32]) ? DST_NEG : DST_POS;
                end
                5'd9: begin
                    mul_a   = 33'(r_cos);
                    mul_b   = 33'(r_cos);
                    iss_dst = DST_COS2;
                end
                5'd10: begin
                    mul_a   = 33'(r_tol);
                    mul_b   = 33'(r_ref);
                    iss_dst = DST_NONE;
                end
                5'd11, 5'd12, 5'd13, 5'd14: begin
                    iss_k   = 2'(r_step[1:0] - 2'd3);
                    mul_a   = iss_k[1] ? r_dot[65:33] : r_dot[32:0];
                    mul_b   = iss_k[0] ? r_dot[65:33] : r_dot[32:0];
                    iss_dst = (iss_k == 2'd0) ? DST_ACCLR : DST_ACC;
                    iss_sh  = 2'(iss_k[1]) + 2'(iss_k[0]);
                end
                5'd15, 5'd16, 5'd17, 5'd18: begin
                    iss_k   = 2'(r_step[1:0] - 2'd3);
                    mul_a   = iss_k[1] ? r_cl[65:33] : r_cl[32:0];
                    mul_b   = iss_k[0] ? r_tl[65:33] : r_tl[32:0];
                    iss_dst = (iss_k == 2'd0) ? DST_ACCLR : DST_ACC;
                    iss_sh  = 2'(iss_k[1]) + 2'(iss_k[0]);
                end
                5'd21, 5'd22, 5'd23, 5'd24: begin
                    iss_k = 2'(r_step[1:0] - 2'd1);
                    case (iss_k)
                        2'd0:    mul_a = r_pp[32:0];
                        2'd1:    mul_a = r_pp[65:33];
                        2'd2:    mul_a = r_pp[98:66];
                        default: mul_a = r_pp[131:99];
                    endcase
                    mul_b   = 33'(r_cos2);
                    iss_dst = (iss_k == 2'd0) ? DST_ACCLR : DST_ACC;
                    iss_sh  = iss_k;
                end
                default: begin
                    mul_a   = '0;
                    mul_b   = '0;
                    iss_dst = DST_NONE;
                end
            endcase
        end
    end

    // align the registered product for the wide accumulator
    always_comb begin
        case (r_sh)
            2'd0:    acc_add = 164'(r_prod);
            2'd1:    acc_add = 164'(r_prod) << 33;
            2'd2:    acc_add = 164'(r_prod) << 66;
            default: acc_add = 164'(r_prod) << 99;
        endcase
    end

    // keep test: zero vector, direction, radius
    assign c_zero   = (r_c[0] == '0) && (r_c[1] == '0) && (r_c[2] == '0);
    assign t_zero   = (r_t[0] == '0) && (r_t[1] == '0) && (r_t[2] == '0);
    assign rad_diff = (r_prad >= r_ref) ? (r_prad - r_ref) : (r_ref - r_prad);
    assign kept     = c_zero || t_zero || ({r_lhs, 32'b0} < r_acc) ||
                      ({rad_diff, 16'b0} > r_rt);

    // decide results and next tube state
    always_comb begin
        pt.x    = r_p[0];
        pt.y    = r_p[1];
        pt.z    = r_p[2];
        pt.rad  = r_prad;
        pt.idx  = r_cnt;
        pt.last = 1'b0;
        pt.shrt = 1'b0;
        cnt1    = r_cnt + 1'b1;
        d_r0    = pt;
        d_r1    = pt;
        d_n     = 2'd0;
        d_phase = r_phase;
        d_cnt   = r_cnt;
        d_anc   = 1'b0;
        d_hold  = 1'b0;
        d_tan   = 1'b0;
        d_ref   = 1'b0;
        unique case (r_phase)
            PH_FIRST: begin
                d_anc  = 1'b1;
                d_hold = 1'b1;
                d_ref  = 1'b1;
                d_cnt  = '0;
                if (r_pfin) begin
                    d_r0      = '0;
                    d_r0.last = 1'b1;
                    d_r0.shrt = 1'b1;
                    d_n       = 2'd1;
                end else begin
                    d_phase = PH_SECOND;
                end
            end
            PH_SECOND: begin
                d_tan    = 1'b1;
                d_r0.x   = r_anc[0];
                d_r0.y   = r_anc[1];
                d_r0.z   = r_anc[2];
                d_r0.rad = r_hold;
                if (r_pfin) begin
                    d_r1.idx  = cnt1;
                    d_r1.last = 1'b1;
                    d_n       = 2'd2;
                    d_cnt     = '0;
                    d_phase   = PH_FIRST;
                end else begin
                    d_n     = 2'd1;
                    d_cnt   = cnt1;
                    d_phase = PH_TEST;
                end
            end
            PH_TEST: begin
                if (r_kept) begin
                    d_n     = 2'd1;
                    d_cnt   = cnt1;
                    d_anc   = 1'b1;
                    d_phase = PH_SKIP;
                end
                if (r_pfin) begin
                    d_cnt   = '0;
                    d_phase = PH_FIRST;
                    if (r_kept) begin
                        d_r1.idx  = cnt1;
                        d_r1.last = 1'b1;
                        d_n       = 2'd2;
                    end else begin
                        d_r0.last = 1'b1;
                        d_n       = 2'd1;
                    end
                end
            end
            PH_SKIP: begin
                d_tan = 1'b1;
                d_ref = 1'b1;
                if (r_pfin) begin
                    d_r0.last = 1'b1;
                    d_n       = 2'd1;
                    d_cnt     = '0;
                    d_phase   = PH_FIRST;
                end else begin
                    d_phase = PH_TEST;
                end
            end
            default: d_phase = PH_FIRST;
        endcase
    end

    // sequencer, tube state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= ST_IDLE;
            r_phase  <= PH_FIRST;
            r_step   <= '0;
            r_kept   <= 1'b0;
            r_nres   <= '0;
            r_ridx   <= 1'b0;
            r_ovalid <= 1'b0;
            r_dst    <= DST_NONE;
            r_sh     <= '0;
            r_anc    <= '{default: '0};
            r_t      <= '{default: '0};
            r_hold   <= '0;
            r_ref    <= '0;
            r_cnt    <= '0;
            r_cos    <= COS_LIMIT_RST;
            r_tol    <= RAD_TOL_RST;
        end else begin
            r_dst <= iss_dst;
            r_sh  <= iss_sh;

            if (cfg_wr) begin
                if (i_paddr[2] == REG_COS_LIMIT) begin
                    r_cos <= i_pwdata[15:0];
                end else begin
                    r_tol <= i_pwdata[15:0];
                end
            end

            // show a new result, or drop the shown one once taken
            if (r_st == ST_EMIT && (!r_ovalid || i_m_tready)) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && i_m_tready) begin
                r_ovalid <= 1'b0;
            end

            unique case (r_st)
                ST_IDLE: begin
                    if (accept) begin
                        r_step <= '0;
                        r_st   <= (r_phase == PH_TEST) ? ST_CALC : ST_DECIDE;
                    end
                end
                ST_CALC: begin
                    r_step <= r_step + 5'd1;
                    if (r_step == STEP_LAST) begin
                        r_kept <= kept;
                        r_st   <= ST_DECIDE;
                    end
                end
                ST_DECIDE: begin
                    r_phase <= d_phase;
                    r_cnt   <= d_cnt;
                    r_nres  <= d_n;
                    r_ridx  <= 1'b0;
                    if (d_anc) begin
                        r_anc <= r_p;
                    end
                    if (d_hold) begin
                        r_hold <= r_prad;
                    end
                    if (d_ref) begin
                        r_ref <= r_prad;
                    end
                    if (d_tan) begin
                        r_t <= r_c;
                    end
                    r_st <= (d_n == 2'd0) ? ST_IDLE : ST_EMIT;
                end
                ST_EMIT: begin
                    // advance one result into a free output register
                    if (!r_ovalid || i_m_tready) begin
                        r_ridx <= ~r_ridx;
                        if (2'(r_ridx) + 2'd1 == r_nres) begin
                            r_st <= ST_IDLE;
                        end
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;

        if (accept) begin
            r_p    <= in_p;
            r_prad <= in_rad;
            r_pfin <= i_s_tlast;
            for (int i = 0; i < 3; i++) begin
                r_c[i] <= 33'(r_anc[i]) - 33'(in_p[i]);
            end
            r_cl  <= '0;
            r_tl  <= '0;
            r_pos <= '0;
            r_neg <= '0;
        end

        // write back the previous step's product
        case (r_dst)
            DST_CL:    r_cl   <= r_cl + r_prod;
            DST_TL:    r_tl   <= r_tl + r_prod;
            DST_POS:   r_pos  <= r_pos + r_prod;
            DST_NEG:   r_neg  <= r_neg + r_prod;
            DST_ACC:   r_acc  <= r_acc + acc_add;
            DST_ACCLR: r_acc  <= acc_add;
            DST_COS2:  r_cos2 <= r_prod[31:0];
            default:   ;
        endcase

        if (r_st == ST_CALC) begin
            if (r_step == STEP_DOT) begin
                r_dot <= (r_pos >= r_neg) ? (r_pos - r_neg) : (r_neg - r_pos);
            end
            if (r_step == STEP_DOT + 5'd1) begin
                r_rt <= r_prod[47:0];
            end
            if (r_step == STEP_LHS) begin
                r_lhs <= r_acc[131:0];
            end
            if (r_step == STEP_PP) begin
                r_pp <= r_acc[131:0];
            end
        end

        if (r_st == ST_DECIDE) begin
            r_res[0] <= d_r0;
            r_res[1] <= d_r1;
        end

        if (r_st == ST_EMIT && (!r_ovalid || i_m_tready)) begin
            r_out <= r_res[r_ridx];
        end
    end

    // result port
    assign o_m_tvalid = r_ovalid;
    assign o_m_tdata  = {16'(r_out.idx), r_out.rad, r_out.z, r_out.y, r_out.x};
    assign o_m_tlast  = r_out.last;
    assign o_m_tuser  = r_out.shrt;

endmodule

`default_nettype wire

// ----- rtl/tcd_chk.sv -----
// ----------------------------------------------------------------------------
// tcd_chk
// Port-level checks of the tube centerline decimator, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_chk (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    input  logic                               o_s_tready,
    input  logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    input  logic [tcd_pkg::OUT_DATA_W-1:0]     o_m_tdata,
    input  logic                               o_m_tlast,
    input  logic [tcd_pkg::OUT_USER_W-1:0]     o_m_tuser,
    input  logic                               o_pready
);
    import tcd_pkg::*;

    // hold a stalled result
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    // a one-point tube reports zeros and closes the line
    a_short: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[0] |-> o_m_tlast && (o_m_tdata == '0))
        else $error("too_short result malformed");

    // the block stops taking items right after one is accepted
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("item accepted while busy");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pready)
        else $error("pready low");

endmodule

bind tube_centerline_decimator tcd_chk u_tcd_chk (.*);

`default_nettype wire

// ----- tb/tb_tube_centerline_decimator.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tube_centerline_decimator
// Streams tube centerlines into the decimator and compares each result item
// with an exact-arithmetic prediction of the kept points. Covers all register
// extremes and idle/stall phases, plus a long receiver hold-off that fills the
// block and a sender pause that drains it.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_tube_centerline_decimator;
    import tcd_pkg::*;

    typedef struct {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
        logic [31:0]        rad;
        logic               fin;
    } t_point;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_SECOND,
        PH_TEST,
        PH_SKIP
    } t_phase;

    // Decimation predictor and queue of expected kept points
    class kept_point_board;
        t_phase             phase;
        logic signed [32:0] anchor [3];
        logic [31:0]        anchor_rad;
        logic signed [32:0] tangent [3];
        logic [31:0]        ref_rad;
        logic [IDX_W-1:0]   count;
        logic [15:0]        cos_lim;
        logic [15:0]        rad_tol;
        t_res               pending [$];
        int                 errors;

        function new();
            phase = PH_FIRST;
            foreach (anchor[i]) anchor[i] = '0;
            foreach (tangent[i]) tangent[i] = '0;
            anchor_rad = '0;
            ref_rad = '0;
            count = '0;
            cos_lim = COS_LIMIT_RST;
            rad_tol = RAD_TOL_RST;
            errors = 0;
        endfunction

        function void push(logic signed [32:0] x, logic signed [32:0] y,
                           logic signed [32:0] z, logic [31:0] rad, logic last,
                           logic shrt);
            t_res r;
            r.x = x[31:0];
            r.y = y[31:0];
            r.z = z[31:0];
            r.rad = rad;
            r.idx = shrt ? '0 : count;
            r.last = last;
            r.shrt = shrt;
            pending.push_back(r);
        endfunction

        // Zero vector, direction break against the anchor, or radius break against the reference radius
        function bit is_break(t_point p);
            logic signed [32:0] c [3];
            logic signed [71:0] dot, cl, tl;
            logic [71:0]        dot_abs;
            logic [199:0]       lhs, rhs;
            logic [63:0]        diff;
            c[0] = anchor[0] - p.x;
            c[1] = anchor[1] - p.y;
            c[2] = anchor[2] - p.z;
            dot = '0;
            cl = '0;
            tl = '0;
            for (int i = 0; i < 3; i++) begin
                dot = dot + c[i] * tangent[i];
                cl = cl + c[i] * c[i];
                tl = tl + tangent[i] * tangent[i];
            end
            if (cl == 0 || tl == 0) return 1;
            dot_abs = dot < 0 ? -dot : dot;
            lhs = dot_abs;
            lhs = (lhs * lhs) << 32;
            rhs = cl;
            rhs = rhs * tl;
            rhs = rhs * cos_lim * cos_lim;
            if (lhs < rhs) return 1;
            diff = p.rad >= ref_rad ? p.rad - ref_rad : ref_rad - p.rad;
            return (diff << 16) > 64'(rad_tol) * ref_rad;
        endfunction

        function void note_point(t_point p);
            logic signed [32:0] px, py, pz;
            px = p.x;
            py = p.y;
            pz = p.z;
            case (phase)
                PH_FIRST: begin
                    anchor[0] = px;
                    anchor[1] = py;
                    anchor[2] = pz;
                    anchor_rad = p.rad;
                    ref_rad = p.rad;
                    count = '0;
                    if (p.fin) push('0, '0, '0, '0, 1'b1, 1'b1);
                    else phase = PH_SECOND;
                end
                PH_SECOND: begin
                    tangent[0] = anchor[0] - px;
                    tangent[1] = anchor[1] - py;
                    tangent[2] = anchor[2] - pz;
                    push(anchor[0], anchor[1], anchor[2], anchor_rad, 1'b0, 1'b0);
                    count++;
                    if (p.fin) push(px, py, pz, p.rad, 1'b1, 1'b0);
                    else phase = PH_TEST;
                end
                PH_TEST: begin
                    if (is_break(p)) begin
                        push(px, py, pz, p.rad, 1'b0, 1'b0);
                        count++;
                        anchor[0] = px;
                        anchor[1] = py;
                        anchor[2] = pz;
                        phase = PH_SKIP;
                    end
                    if (p.fin) push(px, py, pz, p.rad, 1'b1, 1'b0);
                end
                default: begin
                    tangent[0] = anchor[0] - px;
                    tangent[1] = anchor[1] - py;
                    tangent[2] = anchor[2] - pz;
                    ref_rad = p.rad;
                    if (p.fin) push(px, py, pz, p.rad, 1'b1, 1'b0);
                    else phase = PH_TEST;
                end
            endcase
            if (p.fin) begin
                phase = PH_FIRST;
                count = '0;
            end
        endfunction

        function void check_result(t_res got);
            t_res want;
            if (pending.size() == 0) begin
                $error("unexpected result item x=%h idx=%0d", got.x, got.idx);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.x !== want.x) begin
                $error("kept_x expected %h actual %h", want.x, got.x);
                errors++;
            end
            if (got.y !== want.y) begin
                $error("kept_y expected %h actual %h", want.y, got.y);
                errors++;
            end
            if (got.z !== want.z) begin
                $error("kept_z expected %h actual %h", want.z, got.z);
                errors++;
            end
            if (got.rad !== want.rad) begin
                $error("kept_radius expected %h actual %h", want.rad, got.rad);
                errors++;
            end
            if (got.idx !== want.idx) begin
                $error("kept_index expected %0d actual %0d", want.idx, got.idx);
                errors++;
            end
            if (got.last !== want.last) begin
                $error("line_end expected %b actual %b", want.last, got.last);
                errors++;
            end
            if (got.shrt !== want.shrt) begin
                $error("too_short expected %b actual %b", want.shrt, got.shrt);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // pos_x, pos_y, pos_z, tube_radius
    logic                  i_s_tlast;   // final_point
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [OUT_DATA_W-1:0] o_m_tdata;   // kept_x, kept_y, kept_z, kept_radius, kept_index
    logic                  o_m_tlast;   // line_end
    logic [OUT_USER_W-1:0] o_m_tuser;   // too_short
    logic                  i_psel;
    logic                  i_penable;
    logic                  i_pwrite;
    logic [APB_ADDR_W-1:0] i_paddr;
    logic [APB_DATA_W-1:0] i_pwdata;
    logic [APB_DATA_W-1:0] o_prdata;
    logic                  o_pready;

    kept_point_board board;
    int              send_idle_pct;
    int              recv_stall_pct;
    int              hold_left;
    logic signed [31:0] walk_pos [3];
    logic signed [31:0] walk_dir [3];
    logic [31:0]        walk_rad;

    tube_centerline_decimator uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser),
        .i_psel     (i_psel),
        .i_penable  (i_penable),
        .i_pwrite   (i_pwrite),
        .i_paddr    (i_paddr),
        .i_pwdata   (i_pwdata),
        .o_prdata   (o_prdata),
        .o_pready   (o_pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #10ms;
        $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when requested
    initial begin
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                i_m_tready <= 1'b0;
                hold_left = hold_left - 1;
            end else begin
                i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Check each accepted result item
    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got.x = o_m_tdata[31:0];
            got.y = o_m_tdata[63:32];
            got.z = o_m_tdata[95:64];
            got.rad = o_m_tdata[127:96];
            got.idx = o_m_tdata[143:128];
            got.last = o_m_tlast;
            got.shrt = o_m_tuser[0];
            board.check_result(got);
        end
    end

    // Offer one point, idling first at random; return at the accepting edge
    task automatic send_point(t_point p);
        if ($urandom_range(99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {p.rad, p.z, p.y, p.x};
        i_s_tlast <= p.fin;
        do @(posedge i_clk); while (!o_s_tready);
        board.note_point(p);
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain all expected items, then let an untested item settle
    task automatic drain();
        stop_sending();
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // Write one register through a setup phase and an access phase
    task automatic write_reg(logic sel, logic [15:0] value);
        i_psel <= 1'b1;
        i_penable <= 1'b0;
        i_pwrite <= 1'b1;
        i_paddr <= {sel, 2'b00};
        i_pwdata <= {16'h0, value};
        @(posedge i_clk);
        i_penable <= 1'b1;
        do @(posedge i_clk); while (!o_pready);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        if (sel == REG_COS_LIMIT) board.cos_lim = value;
        else board.rad_tol = value;
    endtask

    function automatic t_point make_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                          logic [31:0] rad, logic fin);
        t_point p;
        p.x = x;
        p.y = y;
        p.z = z;
        p.rad = rad;
        p.fin = fin;
        return p;
    endfunction

    // Next point of a gently curving line; sometimes a sharp turn or radius jump
    function automatic t_point walk_step(logic fin);
        int k;
        k = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            if (k < 10) walk_dir[i] = $signed($urandom_range(262144)) - 131072;
            else walk_dir[i] = walk_dir[i] + $signed($urandom_range(4096)) - 2048;
            walk_pos[i] = walk_pos[i] + walk_dir[i];
        end
        if (k >= 90) walk_rad = $urandom;
        else if (k >= 80) walk_rad = walk_rad + ($urandom_range(4096) << 4);
        else walk_rad = walk_rad + $urandom_range(256);
        if (k == 50) return make_point(walk_pos[0], walk_pos[1], walk_pos[2] + 0, walk_rad, fin);
        return make_point(walk_pos[0], walk_pos[1], walk_pos[2], walk_rad, fin);
    endfunction

    // One tube: mostly a well-formed walk, sometimes full-range noise points
    task automatic send_tube(int len);
        t_point p;
        bit     noisy;
        noisy = ($urandom_range(9) == 0);
        for (int i = 0; i < 3; i++) begin
            walk_pos[i] = $urandom;
            walk_dir[i] = $signed($urandom_range(131072)) - 65536;
        end
        walk_rad = $urandom_range(32'h00400000);
        for (int n = 0; n < len; n++) begin
            if (noisy) p = make_point($urandom, $urandom, $urandom, $urandom, 1'b0);
            else if ($urandom_range(19) == 0) p = make_point(walk_pos[0], walk_pos[1],
                                                             walk_pos[2], walk_rad, 1'b0);
            else p = walk_step(1'b0);
            p.fin = (n == len - 1);
            send_point(p);
        end
    endtask

    task automatic random_tubes(int points);
        int sent;
        int len;
        sent = 0;
        while (sent < points) begin
            len = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 14);
            send_tube(len);
            sent = sent + len;
        end
    endtask

    initial begin
        int cos_set [4];
        int tol_set [4];
        board = new();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tlast = 1'b0;
        i_psel = 1'b0;
        i_penable = 1'b0;
        i_pwrite = 1'b0;
        i_paddr = '0;
        i_pwdata = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: single-point tube, two-point tube, extremes, repeated point
        send_point(make_point(32'h7fffffff, 32'h80000000, 32'h0, 32'hffffffff, 1'b1));
        send_point(make_point(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h0, 1'b0));
        send_point(make_point(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'hffffffff, 1'b1));
        // straight line, then a zero difference vector, then a turn kept at the end
        send_point(make_point(32'h0, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h10000, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h20000, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h10000, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h10000, 32'h10000, 32'h0, 32'h10000, 1'b1));
        // straight line with a radius jump, then a zero tangent tube
        send_point(make_point(32'h0, 32'h0, 32'h0, 32'h10000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h10000, 32'h10000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h20000, 32'h20000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h30000, 32'h20000, 1'b0));
        send_point(make_point(32'h0, 32'h0, 32'h40000, 32'h20000, 1'b1));
        send_point(make_point(32'h5, 32'h5, 32'h5, 32'h1, 1'b0));
        send_point(make_point(32'h5, 32'h5, 32'h5, 32'h1, 1'b0));
        send_point(make_point(32'h6, 32'h5, 32'h5, 32'h1, 1'b1));
        drain();

        cos_set = '{0, 65535, 63898, 0};
        tol_set = '{65535, 0, 1638, 0};
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_COS_LIMIT, cos_set[ph] == 0 && ph == 3 ?
                      16'($urandom) : 16'(cos_set[ph]));
            write_reg(REG_RAD_TOL, tol_set[ph] == 0 && ph == 3 ?
                      16'($urandom) : 16'(tol_set[ph]));
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
                default: begin send_idle_pct = 13; recv_stall_pct = 13; end
            endcase
            random_tubes(380);
            // Receiver holds off while the sender keeps offering points
            if (ph == 0) begin
                hold_left = 400;
                random_tubes(40);
            end
            drain();
        end

        // Pause until everything is out, then a last burst at default settings
        write_reg(REG_COS_LIMIT, COS_LIMIT_RST);
        write_reg(REG_RAD_TOL, RAD_TOL_RST);
        send_idle_pct = 0;
        recv_stall_pct = 0;
        random_tubes(120);
        drain();

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
rtl/tcd_pkg.sv
rtl/tube_centerline_decimator.sv
rtl/tcd_chk.sv
tb/tb_tube_centerline_decimator.sv
